// ----- rtl/core/gcp_pkg.sv -----
package gcp_pkg;

   localparam int ValueBits   = 32;
   localparam int CoordBits   = 6;
   localparam int ActionBits  = 3;
   localparam int HeadingBits = 3;
   localparam int StatusBits  = 2;

   typedef enum logic [ActionBits-1:0] {
      ACT_WRITE  = 3'd0,
      ACT_READ   = 3'd1,
      ACT_SET    = 3'd2,
      ACT_STEP   = 3'd3,
      ACT_PEEK   = 3'd4,
      ACT_STRING = 3'd5
   } action_type;

   typedef enum logic [HeadingBits-1:0] {
      DIR_RIGHT = 3'd0,
      DIR_LEFT  = 3'd1,
      DIR_DOWN  = 3'd2,
      DIR_UP    = 3'd3,
      DIR_DONE  = 3'd4
   } dir_type;

   typedef enum logic [StatusBits-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_NONE  = 2'd2,
      ST_LONG  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SRC_ZERO = 2'd0,
      SRC_CELL = 2'd1,
      SRC_BUF  = 2'd2,
      SRC_TERM = 2'd3
   } src_type;

   typedef enum logic [2:0] {
      S_CLEAR     = 3'd0,
      S_IDLE      = 3'd1,
      S_EXEC      = 3'd2,
      S_CELL      = 3'd3,
      S_DELIM     = 3'd4,
      S_ADV       = 3'd5,
      S_EMIT      = 3'd6,
      S_EMIT_WAIT = 3'd7
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       cap;        // capture the accepted item
      logic       clr_wr;     // write zero at the clear address, advance it
      logic       item_wr;    // write the item cell (ignored out of range)
      logic       item_rd;    // read the item cell
      logic       ptr_set;    // load the pointer from the item
      logic       wk_go;      // update the walk position and read the cell there
      logic       wk_load;    // walk starts from the pointer
      logic       wk_move;    // move one cell in the pointer direction
      logic       wk_new;     // restart the move count
      logic       ptr_take;   // pointer takes the walk position
      logic       delim_cap;  // capture the string delimiter
      logic       buf_wr;     // append the current cell to the string buffer
      logic       str_end;    // close the string walk with out_status
      logic       buf_rd;     // read the string buffer at the emit index
      logic       emit_adv;   // advance the emit index
      logic       out_load;   // load the result register
      src_type    out_src;
      status_type out_status;
      logic       out_last;
   } ctl_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [ActionBits-1:0] act;
      logic                  item_ok;
      logic                  set_ok;
      logic                  dir_done;
      logic                  cell_nz;
      logic                  at_limit;
      logic                  is_delim;
      logic                  k_full;
      logic                  emit_done;
      logic                  clr_last;
      logic                  out_free;
   } sts_type;

endpackage

// ----- rtl/core/gcp_req_if.sv -----
interface gcp_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        action;
   logic [5:0]        row;
   logic [5:0]        column;
   logic signed [31:0] value;
   logic [2:0]        heading;

   modport source (output valid, action, row, column, value, heading, input ready);
   modport sink (input valid, action, row, column, value, heading, output ready);
endinterface

// ----- rtl/core/gcp_rsp_if.sv -----
interface gcp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] cell_value;
   logic [5:0]         ptr_row_out;
   logic [5:0]         ptr_col_out;
   logic [1:0]         status;
   logic               last;

   modport source (output valid, cell_value, ptr_row_out, ptr_col_out, status, last,
                   input ready);
   modport sink (input valid, cell_value, ptr_row_out, ptr_col_out, status, last,
                 output ready);
endinterface

// ----- rtl/core/gcp_ram.sv -----
module gcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                rd_en,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/gcp_ctrl.sv -----
module gcp_ctrl import gcp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   state_type state_ff, state_in;
   logic      rd_ok;
   logic      is_str;

   assign rd_ok  = (sts.act == ACT_READ) ? sts.item_ok : sts.set_ok;
   assign is_str = (sts.act == ACT_STRING);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (sts.act)
               ACT_READ, ACT_SET: begin
                  if (rd_ok) state_in = S_CELL;
                  else if (sts.out_free) state_in = S_IDLE;
               end
               ACT_STEP, ACT_PEEK: state_in = S_ADV;
               ACT_STRING:         state_in = S_DELIM;
               default: begin
                  if (sts.out_free) state_in = S_IDLE;
               end
            endcase
         end
         S_CELL: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         S_DELIM: state_in = S_ADV;
         S_ADV: begin
            priority if (sts.cell_nz) begin
               if (is_str) begin
                  if (sts.is_delim || sts.k_full) state_in = S_EMIT;
               end else if (sts.out_free) begin
                  state_in = S_IDLE;
               end
            end else if (sts.at_limit) begin
               if (is_str) state_in = S_EMIT;
               else if (sts.out_free) state_in = S_IDLE;
            end else begin
               // keep walking
               state_in = S_ADV;
            end
         end
         S_EMIT: begin
            if (sts.emit_done) begin
               if (sts.out_free) state_in = S_IDLE;
            end else begin
               state_in = S_EMIT_WAIT;
            end
         end
         S_EMIT_WAIT: begin
            if (sts.out_free) state_in = S_EMIT;
         end
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            ctl.clr_wr = 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            ctl.cap   = req_valid;
         end
         S_EXEC: begin
            unique case (sts.act)
               ACT_READ, ACT_SET: begin
                  if (rd_ok) begin
                     ctl.item_rd = 1'b1;
                     ctl.ptr_set = (sts.act == ACT_SET);
                  end else if (sts.out_free) begin
                     ctl.out_load   = 1'b1;
                     ctl.out_src    = SRC_ZERO;
                     ctl.out_status = ST_RANGE;
                     ctl.out_last   = 1'b1;
                  end
               end
               ACT_STEP, ACT_PEEK: begin
                  ctl.wk_go   = 1'b1;
                  ctl.wk_load = 1'b1;
                  ctl.wk_new  = 1'b1;
                  ctl.wk_move = !sts.dir_done;
               end
               ACT_STRING: begin
                  // read the delimiter under the pointer
                  ctl.wk_go   = 1'b1;
                  ctl.wk_load = 1'b1;
                  ctl.wk_new  = 1'b1;
               end
               ACT_WRITE: begin
                  if (sts.out_free) begin
                     ctl.item_wr    = 1'b1;
                     ctl.out_load   = 1'b1;
                     ctl.out_src    = SRC_ZERO;
                     ctl.out_status = sts.item_ok ? ST_OK : ST_RANGE;
                     ctl.out_last   = 1'b1;
                  end
               end
               default: begin
                  if (sts.out_free) begin
                     ctl.out_load   = 1'b1;
                     ctl.out_src    = SRC_ZERO;
                     ctl.out_status = ST_RANGE;
                     ctl.out_last   = 1'b1;
                  end
               end
            endcase
         end
         S_CELL: begin
            if (sts.out_free) begin
               ctl.out_load   = 1'b1;
               ctl.out_src    = SRC_CELL;
               ctl.out_status = ST_OK;
               ctl.out_last   = 1'b1;
            end
         end
         S_DELIM: begin
            ctl.delim_cap = 1'b1;
            ctl.wk_go     = 1'b1;
            ctl.wk_move   = !sts.dir_done;
         end
         S_ADV: begin
            priority if (sts.cell_nz) begin
               if (is_str) begin
                  priority if (sts.is_delim) begin
                     ctl.ptr_take   = 1'b1;
                     ctl.str_end    = 1'b1;
                     ctl.out_status = ST_OK;
                  end else if (sts.k_full) begin
                     ctl.ptr_take   = 1'b1;
                     ctl.str_end    = 1'b1;
                     ctl.out_status = ST_LONG;
                  end else begin
                     // keep the character, walk on to the next one
                     ctl.buf_wr  = 1'b1;
                     ctl.wk_go   = 1'b1;
                     ctl.wk_new  = 1'b1;
                     ctl.wk_move = !sts.dir_done;
                  end
               end else if (sts.out_free) begin
                  ctl.ptr_take   = (sts.act == ACT_STEP);
                  ctl.out_load   = 1'b1;
                  ctl.out_src    = SRC_CELL;
                  ctl.out_status = ST_OK;
                  ctl.out_last   = 1'b1;
               end
            end else if (sts.at_limit) begin
               if (is_str) begin
                  ctl.ptr_take   = 1'b1;
                  ctl.str_end    = 1'b1;
                  ctl.out_status = ST_NONE;
               end else if (sts.out_free) begin
                  ctl.out_load   = 1'b1;
                  ctl.out_src    = SRC_ZERO;
                  ctl.out_status = ST_NONE;
                  ctl.out_last   = 1'b1;
               end
            end else begin
               ctl.wk_go   = 1'b1;
               ctl.wk_move = 1'b1;
            end
         end
         S_EMIT: begin
            if (sts.emit_done) begin
               if (sts.out_free) begin
                  ctl.out_load = 1'b1;
                  ctl.out_src  = SRC_TERM;
                  ctl.out_last = 1'b1;
               end
            end else begin
               ctl.buf_rd = 1'b1;
            end
         end
         S_EMIT_WAIT: begin
            if (sts.out_free) begin
               ctl.out_load   = 1'b1;
               ctl.out_src    = SRC_BUF;
               ctl.out_status = ST_OK;
               ctl.emit_adv   = 1'b1;
            end
         end
      endcase
   end

endmodule

// ----- rtl/core/gcp_dpath.sv -----
module gcp_dpath import gcp_pkg::*; #(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64,
   parameter int CELL_BITS   = 32,
   parameter int MAX_STRING  = 63
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ActionBits-1:0]       req_action,
   input  logic [CoordBits-1:0]        req_row,
   input  logic [CoordBits-1:0]        req_column,
   input  logic signed [ValueBits-1:0] req_value,
   input  logic [HeadingBits-1:0]      req_heading,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic signed [ValueBits-1:0] rsp_cell_value,
   output logic [CoordBits-1:0]        rsp_ptr_row_out,
   output logic [CoordBits-1:0]        rsp_ptr_col_out,
   output logic [StatusBits-1:0]       rsp_status,
   output logic                        rsp_last,
   input  ctl_type                     ctl,
   output sts_type                     sts
);

   localparam int RowBits  = $clog2(GRID_HEIGHT);
   localparam int ColBits  = $clog2(GRID_WIDTH);
   localparam int Cells    = GRID_WIDTH * GRID_HEIGHT;
   localparam int GridAddr = $clog2(Cells);
   localparam int MaxLen   = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
   localparam int MoveBits = $clog2(MaxLen + 1);
   localparam int CntBits  = $clog2(MAX_STRING + 1);
   localparam int BufAddr  = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1;

   function automatic logic [GridAddr-1:0] cell_addr(input logic [GridAddr-1:0] r,
                                                     input logic [GridAddr-1:0] c);
      return GridAddr'(r * GRID_WIDTH) + c;
   endfunction

   // accepted item
   logic [ActionBits-1:0]       act_ff;
   logic [CoordBits-1:0]        row_ff;
   logic [CoordBits-1:0]        col_ff;
   logic signed [ValueBits-1:0] value_ff;
   logic [HeadingBits-1:0]      heading_ff;

   // pointer and walk position
   logic [RowBits-1:0]  ptr_row_ff, ptr_row_in;
   logic [ColBits-1:0]  ptr_col_ff, ptr_col_in;
   dir_type             ptr_dir_ff, ptr_dir_in;
   logic [RowBits-1:0]  wp_row_ff;
   logic [ColBits-1:0]  wp_col_ff;
   logic [RowBits-1:0]  src_row, nx_row;
   logic [ColBits-1:0]  src_col, nx_col;
   logic [MoveBits-1:0] n_ff;
   logic [MoveBits-1:0] walk_len;

   // string walk
   logic [CELL_BITS-1:0] delim_ff;
   logic [CntBits-1:0]   k_ff;
   logic [CntBits-1:0]   e_ff;
   status_type           str_st_ff;

   logic [GridAddr-1:0] clr_ff;

   // grid and string buffer ports
   logic                  grid_wr_en;
   logic [GridAddr-1:0]   grid_wr_addr;
   logic [CELL_BITS-1:0]  grid_wr_data;
   logic                  grid_rd_en;
   logic [GridAddr-1:0]   grid_rd_addr;
   logic [CELL_BITS-1:0]  grid_rdata;
   logic signed [CELL_BITS-1:0] grid_rdata_s;
   logic [ValueBits-1:0]  buf_rdata;

   logic                  item_ok;
   logic [GridAddr-1:0]   item_addr;
   logic signed [ValueBits-1:0] cell_ext;

   // result register
   logic                        out_valid_ff;
   logic signed [ValueBits-1:0] out_value_ff;
   logic [CoordBits-1:0]        out_row_ff;
   logic [CoordBits-1:0]        out_col_ff;
   status_type                  out_status_ff;
   logic                        out_last_ff;
   logic signed [ValueBits-1:0] out_value_in;
   status_type                  out_status_in;
   logic                        out_free;

   always_ff @(posedge clock) begin
      if (ctl.cap) begin
         act_ff     <= req_action;
         row_ff     <= req_row;
         col_ff     <= req_column;
         value_ff   <= req_value;
         heading_ff <= req_heading;
      end
   end

   assign item_ok   = (int'(row_ff) < GRID_HEIGHT) && (int'(col_ff) < GRID_WIDTH);
   assign item_addr = cell_addr(GridAddr'(row_ff), GridAddr'(col_ff));

   // walk source and one move in the pointer direction
   assign src_row = ctl.wk_load ? ptr_row_ff : wp_row_ff;
   assign src_col = ctl.wk_load ? ptr_col_ff : wp_col_ff;

   always_comb begin
      nx_row = src_row;
      nx_col = src_col;
      if (ctl.wk_move) begin
         unique case (ptr_dir_ff)
            DIR_RIGHT: nx_col = (src_col == ColBits'(GRID_WIDTH - 1)) ? '0 : src_col + 1'b1;
            DIR_LEFT:  nx_col = (src_col == '0) ? ColBits'(GRID_WIDTH - 1) : src_col - 1'b1;
            DIR_DOWN:  nx_row = (src_row == RowBits'(GRID_HEIGHT - 1)) ? '0 : src_row + 1'b1;
            DIR_UP:    nx_row = (src_row == '0) ? RowBits'(GRID_HEIGHT - 1) : src_row - 1'b1;
            default: begin
               // finished: stay put
            end
         endcase
      end
   end

   assign walk_len = (ptr_dir_ff == DIR_RIGHT || ptr_dir_ff == DIR_LEFT) ?
                     MoveBits'(GRID_WIDTH) : MoveBits'(GRID_HEIGHT);

   always_ff @(posedge clock) begin
      if (ctl.wk_go) begin
         wp_row_ff <= nx_row;
         wp_col_ff <= nx_col;
         n_ff      <= (ctl.wk_new ? '0 : n_ff) + MoveBits'(ctl.wk_move);
      end
   end

   always_comb begin
      ptr_row_in = ptr_row_ff;
      ptr_col_in = ptr_col_ff;
      ptr_dir_in = ptr_dir_ff;
      priority if (ctl.ptr_set) begin
         ptr_row_in = RowBits'(row_ff);
         ptr_col_in = ColBits'(col_ff);
         ptr_dir_in = dir_type'(heading_ff);
      end else if (ctl.ptr_take) begin
         ptr_row_in = wp_row_ff;
         ptr_col_in = wp_col_ff;
      end else begin
         // hold the pointer
         ptr_row_in = ptr_row_ff;
         ptr_col_in = ptr_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_row_ff <= '0;
         ptr_col_ff <= '0;
         ptr_dir_ff <= DIR_RIGHT;
         clr_ff     <= '0;
      end else begin
         ptr_row_ff <= ptr_row_in;
         ptr_col_ff <= ptr_col_in;
         ptr_dir_ff <= ptr_dir_in;
         if (ctl.clr_wr) clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.delim_cap) delim_ff <= grid_rdata;
      if (ctl.wk_load) begin
         k_ff <= '0;
      end else if (ctl.buf_wr) begin
         k_ff <= k_ff + 1'b1;
      end
      if (ctl.str_end) begin
         e_ff      <= '0;
         str_st_ff <= ctl.out_status;
      end else if (ctl.emit_adv) begin
         e_ff <= e_ff + 1'b1;
      end
   end

   // grid memory: clear sweep or item write, item read or walk read
   assign grid_wr_en   = ctl.clr_wr || (ctl.item_wr && item_ok);
   assign grid_wr_addr = ctl.clr_wr ? clr_ff : item_addr;
   assign grid_wr_data = ctl.clr_wr ? '0 : CELL_BITS'(value_ff);
   assign grid_rd_en   = ctl.item_rd || ctl.wk_go;
   assign grid_rd_addr = ctl.item_rd ? item_addr :
                         cell_addr(GridAddr'(nx_row), GridAddr'(nx_col));

   gcp_ram #(
      .WIDTH (CELL_BITS),
      .DEPTH (Cells)
   ) u_grid (
      .clock   (clock),
      .wr_en   (grid_wr_en),
      .wr_addr (grid_wr_addr),
      .wr_data (grid_wr_data),
      .rd_en   (grid_rd_en),
      .rd_addr (grid_rd_addr),
      .rd_data (grid_rdata)
   );

   assign grid_rdata_s = grid_rdata;
   assign cell_ext     = ValueBits'(grid_rdata_s);

   gcp_ram #(
      .WIDTH (ValueBits),
      .DEPTH (MAX_STRING)
   ) u_strbuf (
      .clock   (clock),
      .wr_en   (ctl.buf_wr),
      .wr_addr (k_ff[BufAddr-1:0]),
      .wr_data (cell_ext),
      .rd_en   (ctl.buf_rd),
      .rd_addr (e_ff[BufAddr-1:0]),
      .rd_data (buf_rdata)
   );

   // result register
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      unique case (ctl.out_src)
         SRC_CELL: out_value_in = cell_ext;
         SRC_BUF:  out_value_in = buf_rdata;
         default:  out_value_in = '0;
      endcase
      out_status_in = (ctl.out_src == SRC_TERM) ? str_st_ff : ctl.out_status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         out_value_ff  <= out_value_in;
         out_row_ff    <= CoordBits'(ptr_row_in);
         out_col_ff    <= CoordBits'(ptr_col_in);
         out_status_ff <= out_status_in;
         out_last_ff   <= ctl.out_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_cell_value  = out_value_ff;
   assign rsp_ptr_row_out = out_row_ff;
   assign rsp_ptr_col_out = out_col_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_last        = out_last_ff;

   assign sts.act       = act_ff;
   assign sts.item_ok   = item_ok;
   assign sts.set_ok    = item_ok && (heading_ff <= DIR_DONE);
   assign sts.dir_done  = (ptr_dir_ff == DIR_DONE);
   assign sts.cell_nz   = (grid_rdata != '0);
   assign sts.at_limit  = (ptr_dir_ff == DIR_DONE) || (n_ff == walk_len);
   assign sts.is_delim  = (grid_rdata == delim_ff);
   assign sts.k_full    = (k_ff >= CntBits'(MAX_STRING));
   assign sts.emit_done = (e_ff == k_ff);
   assign sts.clr_last  = (clr_ff == GridAddr'(Cells - 1));
   assign sts.out_free  = out_free;

endmodule

// ----- rtl/core/grid_code_pointer_unit.sv -----
// Code grid with an instruction pointer. After reset the grid memory is swept to
// zero, one cell per cycle, over all GRID_WIDTH*GRID_HEIGHT cells (4096 by
// default), and no item is taken meanwhile. Items are handled one at a time
// through the single read port of the grid memory; a step or a peek visits one
// cell after another (up to the grid width or height while skipping zero cells).
// A string read walks one cell per cycle into a character buffer, then reads
// each character back from the buffer into the output register, with the
// terminator last; every result carries the pointer as it stands after the
// whole item. A finished result sits in an output register, so the next item
// is taken while it waits to be picked up.
module grid_code_pointer_unit import gcp_pkg::*; #(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64,
   parameter int CELL_BITS   = 32,
   parameter int MAX_STRING  = 63
) (
   input logic         clock,
   input logic         reset,
   gcp_req_if.sink     req_chan,
   gcp_rsp_if.source   rsp_chan
);

   ctl_type ctl;
   sts_type sts;

   gcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   gcp_dpath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .CELL_BITS   (CELL_BITS),
      .MAX_STRING  (MAX_STRING)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_chan.action),
      .req_row         (req_chan.row),
      .req_column      (req_chan.column),
      .req_value       (req_chan.value),
      .req_heading     (req_chan.heading),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_cell_value  (rsp_chan.cell_value),
      .rsp_ptr_row_out (rsp_chan.ptr_row_out),
      .rsp_ptr_col_out (rsp_chan.ptr_col_out),
      .rsp_status      (rsp_chan.status),
      .rsp_last        (rsp_chan.last),
      .ctl             (ctl),
      .sts             (sts)
   );

endmodule

// ----- rtl/core/gcp_checker.sv -----
module gcp_checker import gcp_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [ValueBits-1:0] rsp_cell_value,
   input logic [CoordBits-1:0]        rsp_ptr_row_out,
   input logic [CoordBits-1:0]        rsp_ptr_col_out,
   input logic [StatusBits-1:0]       rsp_status,
   input logic                        rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value) &&
                                  $stable(rsp_status) && $stable(rsp_last))
      else $error("result changed while stalled");

   // string characters are nonzero and carry ok status
   a_char_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == ST_OK && rsp_cell_value != 0)
      else $error("bad string character");

   // any error result is a final zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_cell_value == 0 && rsp_last)
      else $error("error result not a final zero");

   // as the memory sweep starts after reset: nothing taken, nothing sent
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("activity during clear sweep");

   // the pointer does not move between back-to-back results of one string
   a_str_ptr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         !rsp_valid || (rsp_ptr_row_out == $past(rsp_ptr_row_out) &&
                        rsp_ptr_col_out == $past(rsp_ptr_col_out)))
      else $error("pointer moved within a string");

endmodule

bind grid_code_pointer_unit gcp_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_cell_value  (rsp_chan.cell_value),
   .rsp_ptr_row_out (rsp_chan.ptr_row_out),
   .rsp_ptr_col_out (rsp_chan.ptr_col_out),
   .rsp_status      (rsp_chan.status),
   .rsp_last        (rsp_chan.last)
);
